/* rtl/hbkrd_pkg.sv */
// ----------------------------------------------------------------------------
// hbkrd_pkg
// Shared constants and types for the boot keyboard report differ: field
// widths, event slot layout and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package hbkrd_pkg;

    localparam int KEY_SLOTS   = 6;
    localparam int KEY_W       = 8;
    localparam int MOD_W       = 8;
    localparam int LEN_W       = 7;

    localparam logic [LEN_W-1:0] MIN_REPORT_BYTES = LEN_W'(KEY_SLOTS + 2);
    localparam logic [KEY_W-1:0] ROLLOVER_CODE    = 8'h01;
    localparam logic [KEY_W-1:0] MODIFIER_BASE    = 8'hE0;

    // event slots: modifier bits, then releases, then presses
    localparam int EVENT_SLOTS = MOD_W + 2 * KEY_SLOTS;
    localparam int REL_BASE    = MOD_W;
    localparam int PRS_BASE    = MOD_W + KEY_SLOTS;

    typedef logic [KEY_SLOTS-1:0][KEY_W-1:0] key_array_t;
    typedef logic [EVENT_SLOTS-1:0]          event_mask_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic emit;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic report_ok;
        logic pending;
        logic out_free;
    } status_t;

endpackage

/* rtl/hbkrd_ctrl.sv */
// ----------------------------------------------------------------------------
// hbkrd_ctrl
// Controller: takes a report, has the datapath evaluate it, steps the events
// out one at a time and commits the report as the new reference.
// ----------------------------------------------------------------------------
module hbkrd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  hbkrd_pkg::status_t status,
    output hbkrd_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.report_ok)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (status.pending)
                begin
                    cmd.emit = status.out_free;
                end
                else
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/hbkrd_datapath.sv */
// ----------------------------------------------------------------------------
// hbkrd_datapath
// Datapath: current and previous report registers, the pending event mask,
// lowest-first event pick and the output register.
// ----------------------------------------------------------------------------
module hbkrd_datapath
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  hbkrd_pkg::cmd_t                          cmd,
    output hbkrd_pkg::status_t                       status,
    input  logic [hbkrd_pkg::MOD_W-1:0]              modifiers,
    input  hbkrd_pkg::key_array_t                    keys,
    input  logic [hbkrd_pkg::LEN_W-1:0]              report_length,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic [hbkrd_pkg::KEY_W-1:0]              usage_code,
    output logic                                     pressed,
    output logic                                     last_event
);

    logic [hbkrd_pkg::MOD_W-1:0]    cur_mods_reg;
    hbkrd_pkg::key_array_t          cur_keys_reg;
    logic [hbkrd_pkg::MOD_W-1:0]    prev_mods_reg;
    hbkrd_pkg::key_array_t          prev_keys_reg;
    hbkrd_pkg::event_mask_t         mask_reg;
    hbkrd_pkg::event_mask_t         mask_next;
    hbkrd_pkg::event_mask_t         event_mask;
    hbkrd_pkg::event_mask_t         mask_rest;
    logic [hbkrd_pkg::KEY_W-1:0]    cand_code [hbkrd_pkg::EVENT_SLOTS];
    logic                           cand_level [hbkrd_pkg::EVENT_SLOTS];
    logic [hbkrd_pkg::KEY_W-1:0]    sel_code;
    logic                           sel_level;
    logic                           out_valid_reg;
    logic [hbkrd_pkg::KEY_W-1:0]    usage_code_reg;
    logic                           pressed_reg;
    logic                           last_event_reg;

    function automatic logic key_in(input logic [hbkrd_pkg::KEY_W-1:0] code,
                                    input hbkrd_pkg::key_array_t set);
        logic hit;
        hit = 1'b0;
        for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++)
        begin
            if (set[j] == code)
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    assign status.report_ok = (report_length >= hbkrd_pkg::MIN_REPORT_BYTES) &&
                              (keys[0] != hbkrd_pkg::ROLLOVER_CODE);
    assign status.pending   = |mask_reg;
    assign status.out_free  = !out_valid_reg || !out_stall;

    // candidate events and their flags
    always_comb
    begin
        for (int i = 0; i < hbkrd_pkg::MOD_W; i++)
        begin
            event_mask[i] = cur_mods_reg[i] ^ prev_mods_reg[i];
            cand_code[i]  = hbkrd_pkg::MODIFIER_BASE | hbkrd_pkg::KEY_W'(i);
            cand_level[i] = cur_mods_reg[i];
        end
        for (int j = 0; j < hbkrd_pkg::KEY_SLOTS; j++)
        begin
            event_mask[hbkrd_pkg::REL_BASE + j] =
                (prev_keys_reg[j] != '0) && !key_in(prev_keys_reg[j], cur_keys_reg);
            cand_code[hbkrd_pkg::REL_BASE + j]  = prev_keys_reg[j];
            cand_level[hbkrd_pkg::REL_BASE + j] = 1'b0;
            event_mask[hbkrd_pkg::PRS_BASE + j] =
                (cur_keys_reg[j] != '0) && !key_in(cur_keys_reg[j], prev_keys_reg);
            cand_code[hbkrd_pkg::PRS_BASE + j]  = cur_keys_reg[j];
            cand_level[hbkrd_pkg::PRS_BASE + j] = 1'b1;
        end
    end

    // lowest pending slot goes first
    always_comb
    begin
        sel_code  = '0;
        sel_level = 1'b0;
        for (int i = hbkrd_pkg::EVENT_SLOTS - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                sel_code  = cand_code[i];
                sel_level = cand_level[i];
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - hbkrd_pkg::EVENT_SLOTS'(1));

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.eval)
        begin
            mask_next = event_mask;
        end
        else if (cmd.emit)
        begin
            mask_next = mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_mods_reg <= '0;
            prev_keys_reg <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mask_reg <= mask_next;
            if (cmd.commit)
            begin
                prev_mods_reg <= cur_mods_reg;
                prev_keys_reg <= cur_keys_reg;
            end
            if (status.out_free)
            begin
                out_valid_reg <= cmd.emit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_mods_reg <= modifiers;
            cur_keys_reg <= keys;
        end
        if (cmd.emit)
        begin
            usage_code_reg <= sel_code;
            pressed_reg    <= sel_level;
            last_event_reg <= (mask_rest == '0);
        end
    end

    assign out_valid  = out_valid_reg;
    assign usage_code = usage_code_reg;
    assign pressed    = pressed_reg;
    assign last_event = last_event_reg;

endmodule

/* rtl/hid_boot_keyboard_report_diff.sv */
// ----------------------------------------------------------------------------
// hid_boot_keyboard_report_diff
// Compares each boot keyboard report with the stored one and emits key
// events: modifier changes, then releases, then presses; last one flagged.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  modifiers, key_0..key_5, report_length
//  out      out_valid/out_stall  usage_code, pressed, last_event
//
//  a report yields E events (0 to 20), one event per cycle unless out_stall
//  holds them, out of a single pick-and-clear event mask
//  short and rollover reports are taken and dropped
//  reset clears the stored report, so the first report diffs against zero
//  out_stall holds a valid output register and pauses the event stepping
// ----------------------------------------------------------------------------
module hid_boot_keyboard_report_diff
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [hbkrd_pkg::MOD_W-1:0]    modifiers,
    input  logic [hbkrd_pkg::KEY_W-1:0]    key_0,
    input  logic [hbkrd_pkg::KEY_W-1:0]    key_1,
    input  logic [hbkrd_pkg::KEY_W-1:0]    key_2,
    input  logic [hbkrd_pkg::KEY_W-1:0]    key_3,
    input  logic [hbkrd_pkg::KEY_W-1:0]    key_4,
    input  logic [hbkrd_pkg::KEY_W-1:0]    key_5,
    input  logic [hbkrd_pkg::LEN_W-1:0]    report_length,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [hbkrd_pkg::KEY_W-1:0]    usage_code,
    output logic                           pressed,
    output logic                           last_event
);

    hbkrd_pkg::key_array_t keys;
    hbkrd_pkg::cmd_t       cmd;
    hbkrd_pkg::status_t    status;

    assign keys[0] = key_0;
    assign keys[1] = key_1;
    assign keys[2] = key_2;
    assign keys[3] = key_3;
    assign keys[4] = key_4;
    assign keys[5] = key_5;

    hbkrd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    hbkrd_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .modifiers     (modifiers),
        .keys          (keys),
        .report_length (report_length),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .usage_code    (usage_code),
        .pressed       (pressed),
        .last_event    (last_event)
    );

    // a new report never lands on events still pending
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> !status.pending)
        else $error("report transfer with events pending");

    // an event is only loaded when the output register can take it
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("event loaded into a held output register");

    // the reference report is replaced only after all events are out
    a_commit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!status.pending && !cmd.emit))
        else $error("report committed with events pending");

    // an evaluation always follows a load
    a_load_eval: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.eval)
        else $error("loaded report not evaluated");

endmodule
